// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    // fixed field widths of the stream beats
    localparam int MODE_W     = 3;
    localparam int IN_ITEM_W  = 32;
    localparam int OUT_ITEM_W = 32;
    localparam int STATUS_W   = 2;

    // request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_BACK  = 3'd5
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // command broadcast to every cell of a chain
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_INSERT_TOP = 2'd1,
        OP_APPEND     = 2'd2,
        OP_REMOVE_TOP = 2'd3
    } t_cell_op;

endpackage

// ===== rtl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// one storage cell of a deque chain, takes data from either neighbor or the new item
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int IDX        = 0,
    parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  deq_pkg::t_cell_op     i_op,
    input  logic [CW-1:0]         i_count,
    input  logic [ITEM_WIDTH-1:0] i_item,
    input  logic [ITEM_WIDTH-1:0] i_prev,
    input  logic [ITEM_WIDTH-1:0] i_next,
    output logic [ITEM_WIDTH-1:0] o_data
);
    import deq_pkg::*;

    logic [ITEM_WIDTH-1:0] r_data;
    logic [ITEM_WIDTH-1:0] n_data;
    logic                  w_tail;

    // this cell is the first free slot
    assign w_tail = (i_count == CW'(IDX));

    always_comb begin
        n_data = r_data;
        case (i_op)
            OP_HOLD:       n_data = r_data;
            OP_INSERT_TOP: n_data = i_prev;
            OP_APPEND:     n_data = w_tail ? i_item : r_data;
            OP_REMOVE_TOP: n_data = i_next;
            default:       n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/deq_chain.sv =====
// ----------------------------------------------------------------------------
// deq_chain
// row of cells holding the sequence with its top element in cell zero
// ----------------------------------------------------------------------------
module deq_chain #(
    parameter  int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter  int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  deq_pkg::t_cell_op     i_op,
    input  logic [CW-1:0]         i_count,
    input  logic [ITEM_WIDTH-1:0] i_item,
    output logic [ITEM_WIDTH-1:0] o_top
);
    import deq_pkg::*;

    logic [ITEM_WIDTH-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_prev;
        logic [ITEM_WIDTH-1:0] w_next;

        // cell zero takes the new item on an insert at the top
        if (g == 0) begin : g_first
            assign w_prev = i_item;
        end else begin : g_inner
            assign w_prev = w_data[g-1];
        end

        // the last cell empties on a removal
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_data[g+1];
        end

        deq_cell #(
            .IDX        (g),
            .ITEM_WIDTH (ITEM_WIDTH),
            .CW         (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_count (i_count),
            .i_item  (i_item),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g])
        );
    end

    assign o_top = w_data[0];

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of item words built from two rows of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   requests arrive as beats on the slave stream (mode and item), results
//   leave as beats on the master stream, exactly one result per request
//   modes: push front, push back, pop front, pop back, peek front, peek back
//   no request waits on a search: the front and back elements always sit
//   in cell zero of one of two cell rows
//   the result beat is registered and appears in the cycle after its request
//   beat is taken, and a new request is taken every cycle while the receiver keeps up
//   when the receiver stalls, the result stays in the output register and
//   the slave side is held off until that beat is taken
//   reset clears the element count and the output valid flag; the cell
//   contents are never cleared, only held elements are ever read
//   count, empty and full always describe the deque after the request
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter  int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter  int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int IN_W       = ((deq_pkg::MODE_W + deq_pkg::IN_ITEM_W + 7) / 8) * 8,
    localparam int OUT_RAW    = deq_pkg::OUT_ITEM_W + deq_pkg::STATUS_W + CW + 2,
    localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,  // mode[2:0], item_in[34:3], zero pad
    // result stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata   // item_out, status, count, empty_res,
                                         // full_res, zero pad
);
    import deq_pkg::*;

    // chain a keeps the front in cell zero, chain b keeps the back there;
    // both always hold the same sequence, seen from opposite ends
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [OUT_RAW-1:0]    r_out_data;
    logic [OUT_RAW-1:0]    n_out_data;

    logic                  w_accept;
    logic [MODE_W-1:0]     w_mode;
    logic [ITEM_WIDTH-1:0] w_item;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_full_next;
    logic                  w_empty_next;
    t_cell_op              w_op_a;
    t_cell_op              w_op_b;
    t_cell_op              w_chain_op_a;
    t_cell_op              w_chain_op_b;
    t_status               w_status;
    logic [ITEM_WIDTH-1:0] w_got;
    logic [ITEM_WIDTH-1:0] w_front;
    logic [ITEM_WIDTH-1:0] w_back;

    // request beat fields
    assign w_mode = i_s_tdata[MODE_W-1:0];
    assign w_item = ITEM_WIDTH'(i_s_tdata[MODE_W +: IN_ITEM_W]);

    // output register frees up when its beat is taken
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // request decode
    always_comb begin
        w_op_a   = OP_HOLD;
        w_op_b   = OP_HOLD;
        n_count  = r_count;
        w_status = ST_OK;
        w_got    = '0;
        case (t_mode'(w_mode))
            MODE_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op_a  = OP_INSERT_TOP;
                    w_op_b  = OP_APPEND;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op_a  = OP_APPEND;
                    w_op_b  = OP_INSERT_TOP;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    // chain b simply forgets its deepest entry
                    w_got   = w_front;
                    w_op_a  = OP_REMOVE_TOP;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_got   = w_back;
                    w_op_b  = OP_REMOVE_TOP;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_got = w_front;
                end
            end
            MODE_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_got = w_back;
                end
            end
            default: begin
                // unused codes leave everything as it is
                w_status = ST_OK;
            end
        endcase
    end

    // cells only move on an accepted beat
    assign w_chain_op_a = w_accept ? w_op_a : OP_HOLD;
    assign w_chain_op_b = w_accept ? w_op_b : OP_HOLD;

    deq_chain #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_chain_front (
        .i_clk   (i_clk),
        .i_op    (w_chain_op_a),
        .i_count (r_count),
        .i_item  (w_item),
        .o_top   (w_front)
    );

    deq_chain #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_chain_back (
        .i_clk   (i_clk),
        .i_op    (w_chain_op_b),
        .i_count (r_count),
        .i_item  (w_item),
        .o_top   (w_back)
    );

    // result beat, fields listed from the highest bit down
    assign w_full_next  = (n_count == CW'(DEPTH));
    assign w_empty_next = (n_count == '0);
    assign n_out_data   = {w_full_next, w_empty_next, n_count, w_status,
                           OUT_ITEM_W'(w_got)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above capacity");

    // a successful front pop returns what sat in front and shrinks the count
    a_pop_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_POP_FRONT && !w_empty)
        |=> (r_out_data[OUT_ITEM_W-1:0] == OUT_ITEM_W'($past(w_front)))
            && (r_count == $past(r_count) - CW'(1)))
        else $error("front pop returned wrong item or count");

    // front and back rows agree when a single element is held
    a_single_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1)) |-> (w_front == w_back))
        else $error("front and back rows disagree on a single element");

    // a rejected push leaves the deque full and unchanged
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full
            && (w_mode == MODE_PUSH_FRONT || w_mode == MODE_PUSH_BACK))
        |=> (r_count == $past(r_count))
            && (r_out_data[OUT_ITEM_W +: STATUS_W] == ST_FULL))
        else $error("push on full deque not rejected");

endmodule

// ===== bench/double_ended_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// requests go in on the slave stream, and a local ring model predicts the
// result of each accepted request; every result beat is checked field by
// field against the oldest prediction. a short corner-case pass comes first,
// then fill-to-full and drain-to-empty bursts and a biased random mix, under
// four idling profiles of sender and receiver, with a backlog pause under the stalling receiver
// ----------------------------------------------------------------------------
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH    = DEPTH_DEFAULT;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int REQ_W    = ((MODE_W + IN_ITEM_W + 7) / 8) * 8;
    localparam int RES_RAW  = OUT_ITEM_W + STATUS_W + CNT_W + 2;
    localparam int RES_W    = ((RES_RAW + 7) / 8) * 8;
    // bit offsets of the result fields, lowest first
    localparam int ST_LSB   = OUT_ITEM_W;
    localparam int CNT_LSB  = ST_LSB + STATUS_W;
    localparam int EMP_BIT  = CNT_LSB + CNT_W;
    localparam int FULL_BIT = EMP_BIT + 1;
    // cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // mode codes with no operation behind them
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    // burst lengths that always reach full and then empty
    localparam int FILL_PUSHES = DEPTH + 2;
    localparam int DRAIN_POPS  = DEPTH + 2;

    typedef struct packed {
        logic [OUT_ITEM_W-1:0] item;
        t_status               status;
        logic [CNT_W-1:0]      count;
        logic                  empty;
        logic                  full;
    } t_deq_result;

    // block inputs, all known from time zero
    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             req_valid = 1'b0;
    logic [REQ_W-1:0] req_data  = '0;
    logic             res_ready = 1'b0;

    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [RES_W-1:0] o_m_tdata;

    // idling profile of the current phase, in percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatches = 0;
    int unsigned hang_cycles = 0;

    // predicted results still waiting for their beat
    t_deq_result pending_results[$];

    // local ring model of the deque
    logic [OUT_ITEM_W-1:0] ring_slot[DEPTH];
    logic [3:0]            ring_head  = '0;
    logic [CNT_W-1:0]      ring_count = '0;

    double_ended_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (req_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (req_data),   // mode[2:0], item_in[34:3], zero pad
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (res_ready),
        .o_m_tdata  (o_m_tdata)   // item_out, status, count, empty, full, pad
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction: apply one request to the ring model
    // ------------------------------------------------------------------
    function automatic t_deq_result deque_apply(logic [MODE_W-1:0] mode,
                                                logic [IN_ITEM_W-1:0] item);
        t_deq_result r;
        logic [3:0]  pos;
        r.item   = '0;
        r.status = ST_OK;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (ring_count == CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                end else if (mode == MODE_PUSH_FRONT) begin
                    ring_head            = ring_head - 4'd1;   // wraps below zero
                    ring_slot[ring_head] = item;
                    ring_count           = ring_count + 1'b1;
                end else begin
                    pos            = ring_head + ring_count[3:0];
                    ring_slot[pos] = item;
                    ring_count     = ring_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                if (ring_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT)
                        pos = ring_head;
                    else
                        pos = 4'(ring_head + ring_count - 1'b1);
                    r.item = ring_slot[pos];
                    if (mode == MODE_POP_FRONT) begin
                        ring_head  = ring_head + 4'd1;
                        ring_count = ring_count - 1'b1;
                    end else if (mode == MODE_POP_BACK) begin
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            default: ;   // spare codes only report the state
        endcase
        r.count = ring_count;
        r.empty = (ring_count == '0);
        r.full  = (ring_count == CNT_W'(DEPTH));
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0h, expected %0h",
                 $realtime, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor: check result beats, then predict for accepted requests
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        t_deq_result want;
        t_deq_result got;
        if (i_rst_n) begin
            if (o_m_tvalid && res_ready) begin
                got.item   = o_m_tdata[OUT_ITEM_W-1:0];
                got.status = t_status'(o_m_tdata[ST_LSB +: STATUS_W]);
                got.count  = o_m_tdata[CNT_LSB +: CNT_W];
                got.empty  = o_m_tdata[EMP_BIT];
                got.full   = o_m_tdata[FULL_BIT];
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result beat", got.item, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.item !== want.item)
                        flag_mismatch("item_out", got.item, want.item);
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.count !== want.count)
                        flag_mismatch("count", 32'(got.count), 32'(want.count));
                    if (got.empty !== want.empty)
                        flag_mismatch("empty_res", 32'(got.empty), 32'(want.empty));
                    if (got.full !== want.full)
                        flag_mismatch("full_res", 32'(got.full), 32'(want.full));
                end
            end
            if (req_valid && o_s_tready)
                pending_results.push_back(
                    deque_apply(req_data[MODE_W-1:0], req_data[MODE_W +: IN_ITEM_W]));
        end
    end

    // watchdog: too long without a beat on either side means a hang
    always @(posedge i_clk) begin
        if ((req_valid && o_s_tready) || (o_m_tvalid && res_ready))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT) begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    // receiver: random backpressure per the current phase
    always @(negedge i_clk) begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // sender: one request beat, with random idle cycles ahead of it
    // ------------------------------------------------------------------
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [IN_ITEM_W-1:0] item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(REQ_W - MODE_W - IN_ITEM_W){1'b0}}, item, mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic wait_until_drained();
        @(negedge i_clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [MODE_W-1:0] random_push();
        return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty-deque reads, spare codes, wrap of head below zero, item extremes
    task automatic test_corner_cases();
        send_request(MODE_POP_FRONT,  $urandom());
        send_request(MODE_POP_BACK,   $urandom());
        send_request(MODE_PEEK_FRONT, $urandom());
        send_request(MODE_PEEK_BACK,  $urandom());
        send_request(MODE_SPARE_LO,   $urandom());
        send_request(MODE_SPARE_HI,   $urandom());
        send_request(MODE_PUSH_FRONT, 32'h0000_0000);   // head wraps to the top slot
        send_request(MODE_PUSH_BACK,  32'hffff_ffff);
        send_request(MODE_PUSH_FRONT, 32'ha5a5_5a5a);
        send_request(MODE_PEEK_FRONT, $urandom());
        send_request(MODE_PEEK_BACK,  $urandom());
        send_request(MODE_POP_BACK,   $urandom());
        send_request(MODE_POP_FRONT,  $urandom());
        send_request(MODE_POP_FRONT,  $urandom());
        send_request(MODE_POP_BACK,   $urandom());
    endtask

    // push until full and past it, then pop until empty and past it
    task automatic test_fill_and_drain();
        repeat (FILL_PUSHES) send_request(random_push(), $urandom());
        send_request(MODE_PEEK_FRONT, $urandom());
        send_request(MODE_PEEK_BACK,  $urandom());
        send_request($urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom());
        repeat (DRAIN_POPS)
            send_request($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, $urandom());
    endtask

    // biased random walk so that the count keeps touching both ends
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned push_pct;
        int unsigned pick;
        logic [MODE_W-1:0] mode;
        push_pct = 50;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (k % 20 == 0)
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 50;
                    default: push_pct = 20;
                endcase
            pick = $urandom_range(99);
            if (pick < push_pct)
                mode = random_push();
            else if (pick < 93)
                case ($urandom_range(3))
                    0:       mode = MODE_POP_FRONT;
                    1:       mode = MODE_POP_BACK;
                    2:       mode = MODE_PEEK_FRONT;
                    default: mode = MODE_PEEK_BACK;
                endcase
            else if (pick < 97)
                mode = $urandom_range(1) ? MODE_PEEK_FRONT : MODE_PEEK_BACK;
            else
                mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            send_request(mode, $urandom());
        end
    endtask

    // sender holds off with results outstanding, then carries on
    task automatic test_pause_with_backlog();
        repeat (6) send_request(random_push(), $urandom());
        wait_until_drained();
        repeat (4) send_request(MODE_POP_FRONT, $urandom());
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();

        // no idling, sender idling, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            test_fill_and_drain();
            test_random_mix(120);
            if (phase == 2)
                test_pause_with_backlog();
            test_fill_and_drain();
            test_random_mix(120);
        end

        wait_until_drained();
        // a margin for stray beats
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
